// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: default sizes, port field widths,
// command and status codes. It depends on nothing else.
`default_nettype none

package spq_pkg;

    localparam int SPQ_QUEUE_DEPTH   = 16;
    localparam int SPQ_DATA_BITS     = 32;
    localparam int SPQ_PRIORITY_BITS = 16;

    localparam int SPQ_ITEM_DATA_W = 32;
    localparam int SPQ_ITEM_PRIO_W = 16;
    localparam int SPQ_STATUS_W    = 2;
    localparam int SPQ_COUNT_W     = 5;

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } t_command;

    typedef enum logic [SPQ_STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: control, head copy and output register.
// It depends on spq_pkg and on spq_ram, which holds the entries.
//
//  Channel  Direction  Handshake                 Payload
//  input    in         i_in_valid / o_in_stall   i_command, i_item_data, i_item_priority
//  output   out        o_out_valid / i_out_stall o_status, o_removed_data, o_head_valid,
//                                                o_head_data, o_head_priority, o_entry_count
//
// Entries lie in one RAM as a circular buffer in ascending priority order.
// An enqueue moves up one place every entry whose priority is not below the new one;
// the single write port moves one entry per cycle. A dequeue reads the new head in S_DQ,
// a state it skips when it empties the queue; a rejected transaction goes straight to S_RES.
// A new transaction is taken while the previous result waits in the output register.
// Reset empties the queue at once; the RAM contents need no clearing.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = SPQ_QUEUE_DEPTH,
    parameter int DATA_BITS     = SPQ_DATA_BITS,
    parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_command,
    input  wire logic signed [SPQ_ITEM_DATA_W-1:0] i_item_data,
    input  wire logic signed [SPQ_ITEM_PRIO_W-1:0] i_item_priority,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic             [SPQ_STATUS_W-1:0]    o_status,
    output logic signed      [SPQ_ITEM_DATA_W-1:0] o_removed_data,
    output logic                                   o_head_valid,
    output logic signed      [SPQ_ITEM_DATA_W-1:0] o_head_data,
    output logic signed      [SPQ_ITEM_PRIO_W-1:0] o_head_priority,
    output logic             [SPQ_COUNT_W-1:0]     o_entry_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = DATA_BITS + PRIORITY_BITS;
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_INS  = 5'b00100,
        S_DQ   = 5'b01000,
        S_RES  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head_ptr, n_head_ptr;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_j, n_j;
    logic          r_out_valid;

    logic signed [DATA_BITS-1:0]     r_data, n_data;
    logic signed [PRIORITY_BITS-1:0] r_key, n_key;
    logic signed [DATA_BITS-1:0]     r_head_data, n_head_data;
    logic signed [PRIORITY_BITS-1:0] r_head_prio, n_head_prio;
    t_status                         r_res_status, n_res_status;
    logic signed [DATA_BITS-1:0]     r_removed, n_removed;

    logic [SPQ_STATUS_W-1:0]           r_out_status;
    logic signed [SPQ_ITEM_DATA_W-1:0] r_out_removed;
    logic                              r_out_head_valid;
    logic signed [SPQ_ITEM_DATA_W-1:0] r_out_head_data;
    logic signed [SPQ_ITEM_PRIO_W-1:0] r_out_head_prio;
    logic [SPQ_COUNT_W-1:0]            r_out_count;

    logic          in_accept;
    logic          out_free;
    logic          out_load;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;
    logic signed [PRIORITY_BITS-1:0] rd_prio;
    logic signed [DATA_BITS-1:0]     rd_data;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_PTR : p - 1'b1;
    endfunction

    spq_ram #(
        .WIDTH (WW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_prio   = $signed(ram_rdata[WW-1:DATA_BITS]);
    assign rd_data   = $signed(ram_rdata[DATA_BITS-1:0]);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = (r_state == S_RES) && out_free;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head_ptr   = r_head_ptr;
        n_tail       = r_tail;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_j          = r_j;
        n_data       = r_data;
        n_key        = r_key;
        n_head_data  = r_head_data;
        n_head_prio  = r_head_prio;
        n_res_status = r_res_status;
        n_removed    = r_removed;
        ram_we       = 1'b0;
        ram_waddr    = r_wr_ptr;
        ram_wdata    = {r_key, r_data};
        ram_raddr    = r_rd_ptr;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_removed    = '0;
                    n_res_status = ST_DONE;
                    if (i_command == CMD_ENQUEUE) begin
                        if (r_count == FULL_COUNT) begin
                            n_res_status = ST_FULL;
                            n_state      = S_RES;
                        end else begin
                            n_data   = DATA_BITS'(i_item_data);
                            n_key    = PRIORITY_BITS'(i_item_priority);
                            n_wr_ptr = r_tail;
                            n_tail   = ptr_inc(r_tail);
                            n_count  = r_count + 1'b1;
                            if (r_count == '0) begin
                                n_state = S_INS;
                            end else begin
                                ram_raddr = ptr_dec(r_tail);
                                n_rd_ptr  = ptr_dec(r_tail);
                                n_j       = AW'(r_count - 1'b1);
                                n_state   = S_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_RES;
                        end else begin
                            n_removed  = r_head_data;
                            n_head_ptr = ptr_inc(r_head_ptr);
                            n_count    = r_count - 1'b1;
                            ram_raddr  = ptr_inc(r_head_ptr);
                            n_state    = (r_count == CW'(1)) ? S_RES : S_DQ;
                        end
                    end
                end
            end
            S_CMP: begin
                ram_we = 1'b1;
                if (rd_prio >= r_key) begin
                    ram_wdata = ram_rdata;
                    n_wr_ptr  = r_rd_ptr;
                    if (r_j == '0) begin
                        n_state = S_INS;
                    end else begin
                        ram_raddr = ptr_dec(r_rd_ptr);
                        n_rd_ptr  = ptr_dec(r_rd_ptr);
                        n_j       = r_j - 1'b1;
                    end
                end else begin
                    n_state = S_RES;
                end
            end
            S_INS: begin
                ram_we      = 1'b1;
                n_head_data = r_data;
                n_head_prio = r_key;
                n_state     = S_RES;
            end
            S_DQ: begin
                n_head_data = rd_data;
                n_head_prio = rd_prio;
                n_state     = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head_ptr  <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_head_ptr <= n_head_ptr;
            r_tail     <= n_tail;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr     <= n_rd_ptr;
        r_wr_ptr     <= n_wr_ptr;
        r_j          <= n_j;
        r_data       <= n_data;
        r_key        <= n_key;
        r_head_data  <= n_head_data;
        r_head_prio  <= n_head_prio;
        r_res_status <= n_res_status;
        r_removed    <= n_removed;
        if (out_load) begin
            r_out_status     <= r_res_status;
            r_out_removed    <= SPQ_ITEM_DATA_W'(r_removed);
            r_out_head_valid <= (r_count != '0);
            r_out_head_data  <= (r_count != '0) ? SPQ_ITEM_DATA_W'(r_head_data) : '0;
            r_out_head_prio  <= (r_count != '0) ? SPQ_ITEM_PRIO_W'(r_head_prio) : '0;
            r_out_count      <= SPQ_COUNT_W'(r_count);
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_data  = r_out_removed;
    assign o_head_valid    = r_out_head_valid;
    assign o_head_data     = r_out_head_data;
    assign o_head_priority = r_out_head_prio;
    assign o_entry_count   = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("Entry count exceeds the queue depth.");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && ram_we && rd_prio >= r_key && r_j != '0)
            |-> ram_waddr != ram_raddr)
        else $error("Shift write collides with the next read.");

    a_dequeue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_command == CMD_DEQUEUE && r_count != '0)
            |=> r_count == $past(r_count) - 1'b1)
        else $error("Dequeue did not reduce the entry count.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_res_status == ST_FULL) |-> r_count == FULL_COUNT)
        else $error("Full status reported on a queue that is not full.");

endmodule

`default_nettype wire

// ===== rtl/spq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// It depends on nothing else.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== tb/spq_checker.sv =====
// Checker for the sorted priority queue: keeps its own sorted copy of the entries,
// predicts one report per accepted command and compares the reports that leave the block.
// It depends on spq_pkg for the field widths and the command and status codes.

module spq_checker
    import spq_pkg::*;
(
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire logic                              i_command,
    input  wire logic signed [SPQ_ITEM_DATA_W-1:0] i_item_data,
    input  wire logic signed [SPQ_ITEM_PRIO_W-1:0] i_item_priority,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic             [SPQ_STATUS_W-1:0]    i_status,
    input  wire logic signed      [SPQ_ITEM_DATA_W-1:0] i_removed_data,
    input  wire logic                              i_head_valid,
    input  wire logic signed      [SPQ_ITEM_DATA_W-1:0] i_head_data,
    input  wire logic signed      [SPQ_ITEM_PRIO_W-1:0] i_head_priority,
    input  wire logic             [SPQ_COUNT_W-1:0]     i_entry_count,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status                           status;
        logic signed [SPQ_ITEM_DATA_W-1:0] removed_data;
        logic                              head_valid;
        logic signed [SPQ_ITEM_DATA_W-1:0] head_data;
        logic signed [SPQ_ITEM_PRIO_W-1:0] head_priority;
        logic        [SPQ_COUNT_W-1:0]     entry_count;
    } t_queue_report;

    logic signed [SPQ_DATA_BITS-1:0]     entry_data [SPQ_QUEUE_DEPTH];
    logic signed [SPQ_PRIORITY_BITS-1:0] entry_priority [SPQ_QUEUE_DEPTH];
    int                                  entry_total = 0;
    t_queue_report                       awaited_reports [$];
    int                                  fail_total = 0;

    initial o_pending = 0;
    assign o_fail_count = fail_total;

    function automatic t_queue_report apply_command(
        input t_command                            cmd,
        input logic signed [SPQ_ITEM_DATA_W-1:0]   data,
        input logic signed [SPQ_ITEM_PRIO_W-1:0]   prio
    );
        t_queue_report report;
        int            slot;
        report.status       = ST_DONE;
        report.removed_data = '0;
        if (cmd == CMD_ENQUEUE) begin
            if (entry_total >= SPQ_QUEUE_DEPTH) begin
                report.status = ST_FULL;
            end else begin
                slot = 0;
                while (slot < entry_total && entry_priority[slot] < prio) slot++;
                for (int k = entry_total; k > slot; k--) begin
                    entry_data[k]     = entry_data[k-1];
                    entry_priority[k] = entry_priority[k-1];
                end
                entry_data[slot]     = data;
                entry_priority[slot] = prio;
                entry_total++;
            end
        end else begin
            if (entry_total == 0) begin
                report.status = ST_EMPTY;
            end else begin
                report.removed_data = entry_data[0];
                for (int k = 1; k < entry_total; k++) begin
                    entry_data[k-1]     = entry_data[k];
                    entry_priority[k-1] = entry_priority[k];
                end
                entry_total--;
            end
        end
        report.head_valid    = (entry_total > 0);
        report.head_data     = (entry_total > 0) ? entry_data[0] : '0;
        report.head_priority = (entry_total > 0) ? entry_priority[0] : '0;
        report.entry_count   = entry_total[SPQ_COUNT_W-1:0];
        return report;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_queue_report want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_reports.size() == 0) begin
                    $error("report with no transaction awaiting one: status %0h count %0d",
                           i_status, i_entry_count);
                    fail_total++;
                end else begin
                    want = awaited_reports.pop_front();
                    compare_field("status", want.status, i_status);
                    compare_field("removed_data", want.removed_data, i_removed_data);
                    compare_field("head_valid", want.head_valid, i_head_valid);
                    compare_field("head_data", want.head_data, i_head_data);
                    compare_field("head_priority", want.head_priority, i_head_priority);
                    compare_field("entry_count", want.entry_count, i_entry_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_reports.push_back(apply_command(t_command'(i_command), i_item_data,
                                                        i_item_priority));
            end
        end
        o_pending <= awaited_reports.size();
    end

endmodule

// ===== tb/tb_sorted_priority_queue.sv =====
// Testbench top for the sorted priority queue: clock, reset, command stimulus, output stall,
// watchdog and verdict. It depends on spq_pkg, sorted_priority_queue and spq_checker.

module tb_sorted_priority_queue
    import spq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 330;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 80;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic                              i_command = CMD_ENQUEUE;
    logic signed [SPQ_ITEM_DATA_W-1:0] i_item_data = '0;
    logic signed [SPQ_ITEM_PRIO_W-1:0] i_item_priority = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic        [SPQ_STATUS_W-1:0]    o_status;
    logic signed [SPQ_ITEM_DATA_W-1:0] o_removed_data;
    logic                              o_head_valid;
    logic signed [SPQ_ITEM_DATA_W-1:0] o_head_data;
    logic signed [SPQ_ITEM_PRIO_W-1:0] o_head_priority;
    logic        [SPQ_COUNT_W-1:0]     o_entry_count;

    int fail_count;
    int pending_reports;
    int send_idle_pct = 6;
    int recv_stall_pct = 58;
    int quiet_cycles = 0;

    always #5ns i_clk = ~i_clk;

    sorted_priority_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_data  (o_removed_data),
        .o_head_valid    (o_head_valid),
        .o_head_data     (o_head_data),
        .o_head_priority (o_head_priority),
        .o_entry_count   (o_entry_count)
    );

    spq_checker queue_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_removed_data  (o_removed_data),
        .i_head_valid    (o_head_valid),
        .i_head_data     (o_head_data),
        .i_head_priority (o_head_priority),
        .i_entry_count   (o_entry_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending_reports)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_command(input t_command cmd,
                                input logic signed [SPQ_ITEM_DATA_W-1:0] data,
                                input logic signed [SPQ_ITEM_PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_item_data     <= data;
        i_item_priority <= prio;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin
        int                                burst_left;
        int                                enqueue_pct;
        t_command                          cmd;
        logic signed [SPQ_ITEM_PRIO_W-1:0] prio;
        burst_left  = 0;
        enqueue_pct = 50;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue, extreme values, ties at zero and at both ends, fill to full,
        // one enqueue past full, then part of a drain.
        send_command(CMD_DEQUEUE, 32'sh1234_5678, 16'sh0);
        send_command(CMD_ENQUEUE, 32'sh7FFF_FFFF, 16'sh7FFF);
        send_command(CMD_ENQUEUE, 32'sh8000_0000, 16'sh8000);
        send_command(CMD_ENQUEUE, 32'sh0, 16'sh0);
        send_command(CMD_ENQUEUE, -32'sd1, -16'sd1);
        send_command(CMD_ENQUEUE, 32'sd1, 16'sh0);
        send_command(CMD_ENQUEUE, 32'sd2, 16'sh0);
        send_command(CMD_ENQUEUE, 32'sd3, 16'sh7FFF);
        send_command(CMD_ENQUEUE, 32'sd4, 16'sh8000);
        for (int k = 0; k < 8; k++) begin
            send_command(CMD_ENQUEUE, $urandom, 16'(k * 4099 - 16000));
        end
        send_command(CMD_ENQUEUE, 32'h5A5A_A5A5, -16'sd40);
        repeat (6) send_command(CMD_DEQUEUE, $urandom, 16'($urandom));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 58;
                end
                1: begin
                    send_idle_pct  = 58;
                    recv_stall_pct = 6;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(24, 4);
                    case ($urandom_range(2))
                        0: enqueue_pct = 85;
                        1: enqueue_pct = 15;
                        default: enqueue_pct = 50;
                    endcase
                end
                burst_left--;
                cmd = ($urandom_range(99) < enqueue_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
                case ($urandom_range(9))
                    0, 1, 2, 3: prio = 16'($urandom_range(3)) - 16'sd2;
                    4, 5: begin
                        case ($urandom_range(3))
                            0: prio = 16'sh8000;
                            1: prio = 16'sh7FFF;
                            2: prio = 16'sh0;
                            default: prio = -16'sd1;
                        endcase
                    end
                    default: prio = 16'($urandom);
                endcase
                send_command(cmd, $urandom, prio);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_reports != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_reports == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
